FILE: sv/apc_pkg.sv
`timescale 1ns / 1ps

package apc_pkg;

  localparam int MAX_STAGES       = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int SMP_W      = 24;
  localparam int STEP_W     = 32;
  localparam int DEPTH_W    = 15;
  localparam int WET_W      = 16;
  localparam int STAGES_W   = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int STG_IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int STG_CNT_W = STG_IDX_W + 1;

  localparam int TAB_IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int TAB_AW    = TAB_IDX_W + 1;
  localparam int SINE_W    = 15;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int RND_W   = MUL_P_W - 15;
  localparam int SUM_W   = 29;
  localparam int COEF_W  = 16;

  localparam logic [STEP_W-1:0]   RST_LFO_STEP = 32'd134218;
  localparam logic [DEPTH_W-1:0]  RST_DEPTH    = 15'd3277;
  localparam logic [WET_W-1:0]    RST_WET_GAIN = 16'd16384;
  localparam logic [STAGES_W-1:0] RST_STAGES   = 5'd15;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LFO_STEP      = 8'd0,
    CFG_DEPTH         = 8'd1,
    CFG_WET_GAIN      = 8'd2,
    CFG_STAGES_IN_USE = 8'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GMUL,
    ST_GRND,
    ST_SMUL,
    ST_SADD,
    ST_WMUL,
    ST_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    MUL_DEPTH,
    MUL_STAGE,
    MUL_WET
  } mul_sel_e;

  typedef struct packed {
    logic                 mul_en;
    mul_sel_e             mul_sel;
    logic                 g_load;
    logic                 stage_wr;
    logic                 out_load;
    logic [STG_IDX_W-1:0] stage_idx;
  } apc_ctl_t;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_TABLE_DEPTH+1];

  function automatic logic [63:0] taylor_next(logic [63:0] term, logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // quarter-wave entry k, Q30 taylor series with truncated products
  function automatic logic [SINE_W-1:0] quarter_sine(int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    logic [63:0] e;
    x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    term = x;
    sum  = longint'(x);
    term = taylor_next(term, x) / 6;
    sum  = sum - longint'(term);
    term = taylor_next(term, x) / 20;
    sum  = sum + longint'(term);
    term = taylor_next(term, x) / 42;
    sum  = sum - longint'(term);
    term = taylor_next(term, x) / 72;
    sum  = sum + longint'(term);
    term = taylor_next(term, x) / 110;
    sum  = sum - longint'(term);
    term = taylor_next(term, x) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    e = (64'(sum) + 64'd16384) >> 15;
    if (e > 64'd32767) e = 64'd32767;
    return e[SINE_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic logic signed [SMP_W-1:0] sat24(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(8388607);
    lo = -SUM_W'(8388608);
    if (v > hi) return SMP_W'(hi);
    if (v < lo) return SMP_W'(lo);
    return v[SMP_W-1:0];
  endfunction

endpackage

FILE: sv/apc_in_if.sv
`timescale 1ns / 1ps

interface apc_in_if import apc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: sv/apc_out_if.sv
`timescale 1ns / 1ps

interface apc_out_if import apc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: sv/apc_mul.sv
`timescale 1ns / 1ps

module apc_mul import apc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  // product holds until the next issue
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

FILE: sv/apc_lfo.sv
`timescale 1ns / 1ps

module apc_lfo import apc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [STEP_W-1:0] step_i,
  input  logic              adv_i,
  output logic [SINE_W-1:0] mag_o,
  output logic              neg_o
);

  logic [STEP_W-1:0]    phase_q;
  logic [STEP_W-1:0]    phase_d;
  logic [TAB_IDX_W-1:0] idx;
  logic [TAB_AW-1:0]    addr;

  assign phase_d = phase_q + step_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
    end
  end

  // odd quadrants read the table backwards
  assign idx  = phase_q[STEP_W-3 -: TAB_IDX_W];
  assign addr = phase_q[STEP_W-2] ? (TAB_AW'(SINE_TABLE_DEPTH) - {1'b0, idx})
                                  : {1'b0, idx};

  assign mag_o = SINE_TAB[addr];
  assign neg_o = phase_q[STEP_W-1];

endmodule

FILE: sv/apc_seq.sv
`timescale 1ns / 1ps

module apc_seq import apc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  input  logic [STG_CNT_W-1:0] n_stages_i,
  output logic                 in_ready_o,
  output apc_ctl_t             ctl_o
);

  seq_state_e           state_q;
  seq_state_e           state_d;
  logic [STG_IDX_W-1:0] k_q;
  logic [STG_IDX_W-1:0] k_d;
  logic                 last;

  assign last = (({1'b0, k_q} + STG_CNT_W'(1)) == n_stages_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_GMUL;
      ST_GMUL: state_d = ST_GRND;
      ST_GRND: state_d = (n_stages_i == '0) ? ST_WMUL : ST_SMUL;
      ST_SMUL: state_d = ST_SADD;
      ST_SADD: state_d = last ? ST_WMUL : ST_SMUL;
      ST_WMUL: state_d = ST_DONE;
      ST_DONE: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    ctl_o           = '0;
    ctl_o.mul_sel   = MUL_DEPTH;
    ctl_o.stage_idx = k_q;
    k_d             = k_q;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_GMUL: ctl_o.mul_en = 1'b1;
      ST_GRND: begin
        ctl_o.g_load = 1'b1;
        k_d          = '0;
      end
      ST_SMUL: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_STAGE;
      end
      ST_SADD: begin
        ctl_o.stage_wr = 1'b1;
        k_d            = k_q + STG_IDX_W'(1);
      end
      ST_WMUL: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_WET;
      end
      ST_DONE: ctl_o.out_load = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

FILE: sv/allpass_cascade_phaser_unit.sv
`timescale 1ns / 1ps
// one sample at a time through a single shared 17x25 multiplier
// states per sample: idle, gain multiply, gain round, then per active stage a
// multiply state and an add state, then wet multiply and done
// result is registered in the done state when the output is free; a new sample
// is taken while the previous result still waits
// rst_ni clears lfo phase, stage history and handshake state, loads default registers

module allpass_cascade_phaser_unit import apc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  apc_in_if.sink                in_i,
  apc_out_if.source             out_o
);

  logic [STEP_W-1:0]   lfo_step_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [WET_W-1:0]    wet_gain_q;
  logic [STAGES_W-1:0] stages_q;

  logic signed [SMP_W-1:0]  dry_q;
  logic signed [SMP_W-1:0]  filt_q;
  logic signed [COEF_W-1:0] g_q;
  logic signed [COEF_W-1:0] g_d;
  logic signed [SMP_W-1:0]  prev_in_q  [MAX_STAGES];
  logic signed [SMP_W-1:0]  prev_out_q [MAX_STAGES];
  logic signed [SMP_W-1:0]  out_data_q;
  logic                     out_valid_q;

  apc_ctl_t                  ctl;
  logic                      in_ready;
  logic                      out_free;
  logic [STG_CNT_W-1:0]      n_stages;
  logic [SINE_W-1:0]         sine_mag;
  logic                      sine_neg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] prod_bias;
  logic signed [RND_W-1:0]   rnd;
  logic [COEF_W-1:0]         g_mag;
  logic signed [SMP_W-1:0]   stage_y;
  logic signed [SMP_W-1:0]   result;
  logic                      in_beat;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_step_q <= RST_LFO_STEP;
      depth_q    <= RST_DEPTH;
      wet_gain_q <= RST_WET_GAIN;
      stages_q   <= RST_STAGES;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LFO_STEP:      lfo_step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_DEPTH:         depth_q    <= cfg_wdata_i[DEPTH_W-1:0];
        CFG_WET_GAIN:      wet_gain_q <= cfg_wdata_i[WET_W-1:0];
        CFG_STAGES_IN_USE: stages_q   <= cfg_wdata_i[STAGES_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_stages = (32'(stages_q) > 32'(MAX_STAGES)) ? STG_CNT_W'(MAX_STAGES)
                                                      : STG_CNT_W'(stages_q);

  assign out_free = !out_valid_q || out_o.ready;
  assign in_beat  = in_i.valid && in_ready;

  apc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .n_stages_i (n_stages),
    .in_ready_o (in_ready),
    .ctl_o      (ctl)
  );

  apc_lfo u_lfo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (lfo_step_q),
    .adv_i  (ctl.out_load),
    .mag_o  (sine_mag),
    .neg_o  (sine_neg)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul_sel)
      MUL_DEPTH: begin
        mul_a = MUL_A_W'(signed'({1'b0, depth_q}));
        mul_b = MUL_B_W'(signed'({1'b0, sine_mag}));
      end
      MUL_STAGE: begin
        mul_a = MUL_A_W'(g_q);
        mul_b = MUL_B_W'(prev_out_q[ctl.stage_idx]) - MUL_B_W'(filt_q);
      end
      MUL_WET: begin
        mul_a = MUL_A_W'(signed'({1'b0, wet_gain_q}));
        mul_b = MUL_B_W'(filt_q);
      end
      default: ;
    endcase
  end

  apc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (ctl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // round half up: floor((p + 2^14) / 2^15)
  assign prod_bias = prod + MUL_P_W'(16384);
  assign rnd       = prod_bias[MUL_P_W-1:15];
  assign g_mag     = prod_bias[15+COEF_W-1:15];
  assign g_d       = sine_neg ? -signed'(g_mag) : signed'(g_mag);

  assign stage_y = sat24(SUM_W'(prev_in_q[ctl.stage_idx]) + SUM_W'(rnd));
  assign result  = sat24(SUM_W'(dry_q) + SUM_W'(rnd));

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      dry_q  <= in_i.sample_in;
      filt_q <= in_i.sample_in;
    end else if (ctl.stage_wr) begin
      filt_q <= stage_y;
    end
    if (ctl.g_load) begin
      g_q <= g_d;
    end
    if (ctl.out_load) begin
      out_data_q <= result;
    end
  end

  // per-stage history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
        prev_in_q[i]  <= '0;
        prev_out_q[i] <= '0;
      end
    end else if (ctl.stage_wr) begin
      prev_in_q[ctl.stage_idx]  <= filt_q;
      prev_out_q[ctl.stage_idx] <= stage_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule
